### rtl/core/fca_pkg.sv
// Shared types, codes and constants of the FAT chain allocator.
// Used by every module of the block but fca_ram; depends on nothing.
package fca_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int VAL_W     = 16;
  localparam int OPC_W     = 2;
  localparam int ST_W      = 2;

  localparam logic [VAL_W-1:0] ENTRY_FREE = 16'h0000;
  localparam logic [VAL_W-1:0] ENTRY_EOC  = 16'hFFFF;

  localparam logic [REG_W-1:0] DATA_START_RST  = 13'd82;
  localparam logic [REG_W-1:0] ALLOC_LIMIT_RST = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOC_LIMIT = 1'd1;

  localparam logic [OPC_W-1:0] OP_NEXT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_SET   = 2'd1;
  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd2;
  localparam logic [OPC_W-1:0] OP_FREE  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_LONG  = 2'd3;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SET,
    WR_EOC,
    WR_ZERO,
    WR_CLEAR
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_READ,
    RES_READ_RANGE,
    RES_SET_OK,
    RES_SET_RANGE,
    RES_ALLOC,
    RES_FULL,
    RES_FREE
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     rd_en;
    logic     rd_scan;
    wr_sel_t  wr_sel;
    logic     scan_step;
    logic     free_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
    logic     clr_step;
  } fca_cmd_t;

  typedef struct packed {
    logic cur_eoc;
    logic cur_free;
    logic cur_oor;
    logic cnt_full;
    logic scan_done;
    logic rdata_free;
    logic clr_last;
  } fca_stat_t;

endpackage

### rtl/core/fca_in_if.sv
// Request channel of the FAT chain allocator: valid, ready and one request word.
// Depends on fca_pkg for field widths.
interface fca_in_if;
  logic                       valid;
  logic                       ready;
  logic [fca_pkg::OPC_W-1:0]  opcode;
  logic [fca_pkg::VAL_W-1:0]  block;
  logic [fca_pkg::VAL_W-1:0]  value;

  modport source (output valid, output opcode, output block, output value, input ready);
  modport sink   (input valid, input opcode, input block, input value, output ready);
endinterface

### rtl/core/fca_out_if.sv
// Result channel of the FAT chain allocator: valid, ready and one result word.
// Depends on fca_pkg for field widths.
interface fca_out_if;
  logic                       valid;
  logic                       ready;
  logic [fca_pkg::VAL_W-1:0]  result_value;
  logic [fca_pkg::REG_W-1:0]  freed_count;
  logic [fca_pkg::ST_W-1:0]   status;

  modport source (output valid, output result_value, output freed_count, output status,
                  input ready);
  modport sink   (input valid, input result_value, input freed_count, input status,
                  output ready);
endinterface

### rtl/core/fca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; holds the allocation table.
module fca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/fca_ctrl.sv
// Controller of the FAT chain allocator: sequences clearing, table access and handshakes.
// Depends on fca_pkg; drives fca_dp through command and status structs.
module fca_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [fca_pkg::OPC_W-1:0] in_opcode,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  fca_pkg::fca_stat_t        stat,
  output fca_pkg::fca_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_DATA,
    S_SET,
    S_SCAN,
    S_SCAN_DATA,
    S_WALK,
    S_WALK_DATA,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.wr_sel  = fca_pkg::WR_NONE;
    cmd.res_sel = fca_pkg::RES_READ;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_sel   = fca_pkg::WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          unique case (in_opcode)
            fca_pkg::OP_NEXT:  state_nxt = S_READ;
            fca_pkg::OP_SET:   state_nxt = S_SET;
            fca_pkg::OP_ALLOC: state_nxt = S_SCAN;
            default:           state_nxt = S_WALK;
          endcase
        end
      end
      S_READ: begin
        if (stat.cur_oor) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fca_pkg::RES_READ_RANGE;
          state_nxt    = S_EMIT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_READ_DATA;
        end
      end
      S_READ_DATA: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = fca_pkg::RES_READ;
        state_nxt    = S_EMIT;
      end
      S_SET: begin
        cmd.res_load = 1'b1;
        if (stat.cur_oor) begin
          cmd.res_sel = fca_pkg::RES_SET_RANGE;
        end else begin
          cmd.wr_sel  = fca_pkg::WR_SET;
          cmd.res_sel = fca_pkg::RES_SET_OK;
        end
        state_nxt = S_EMIT;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fca_pkg::RES_FULL;
          state_nxt    = S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_DATA;
        end
      end
      S_SCAN_DATA: begin
        if (stat.rdata_free) begin
          cmd.wr_sel   = fca_pkg::WR_EOC;
          cmd.res_load = 1'b1;
          cmd.res_sel  = fca_pkg::RES_ALLOC;
          state_nxt    = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_WALK: begin
        if (stat.cur_eoc || stat.cur_free || stat.cur_oor || stat.cnt_full) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = fca_pkg::RES_FREE;
          state_nxt    = S_EMIT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_WALK_DATA;
        end
      end
      S_WALK_DATA: begin
        cmd.wr_sel    = fca_pkg::WR_ZERO;
        cmd.free_step = 1'b1;
        state_nxt     = S_WALK;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/core/fca_dp.sv
// Datapath of the FAT chain allocator: configuration, walk and scan registers, table RAM.
// Depends on fca_pkg and fca_ram; obeys commands from fca_ctrl.
module fca_dp #(
  parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fca_pkg::REG_W-1:0]     cfg_wdata,
  input  logic [fca_pkg::VAL_W-1:0]     in_block,
  input  logic [fca_pkg::VAL_W-1:0]     in_value,
  input  fca_pkg::fca_cmd_t             cmd,
  output fca_pkg::fca_stat_t            stat,
  output logic [fca_pkg::VAL_W-1:0]     out_result_value,
  output logic [fca_pkg::REG_W-1:0]     out_freed_count,
  output logic [fca_pkg::ST_W-1:0]      out_status
);

  localparam int AW  = $clog2(TABLE_ENTRIES);
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int SCW = (CW > fca_pkg::REG_W) ? CW : fca_pkg::REG_W;

  logic [fca_pkg::REG_W-1:0] data_start_r, alloc_limit_r;
  logic [fca_pkg::VAL_W-1:0] cur_r, val_r;
  logic [SCW-1:0]            scan_r;
  logic [CW-1:0]             count_r;
  logic [AW-1:0]             clr_r;
  logic [fca_pkg::VAL_W-1:0] res_value_r, out_value_r;
  logic [fca_pkg::REG_W-1:0] res_cnt_r, out_cnt_r;
  logic [fca_pkg::ST_W-1:0]  res_st_r, out_st_r;

  logic [SCW-1:0]            lim_n, alloc_ext, lim;
  logic [SCW-1:0]            cnt_x;
  logic [fca_pkg::ST_W-1:0]  free_st;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [fca_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

  assign lim_n     = SCW'(TABLE_ENTRIES);
  assign alloc_ext = SCW'(alloc_limit_r);
  assign lim       = (alloc_ext < lim_n) ? alloc_ext : lim_n;
  assign cnt_x     = SCW'(count_r);

  assign stat.cur_eoc    = (cur_r == fca_pkg::ENTRY_EOC);
  assign stat.cur_free   = (cur_r == fca_pkg::ENTRY_FREE);
  assign stat.cur_oor    = (cur_r >= fca_pkg::VAL_W'(TABLE_ENTRIES));
  assign stat.cnt_full   = (count_r == CW'(TABLE_ENTRIES));
  assign stat.scan_done  = (scan_r >= lim);
  assign stat.rdata_free = (ram_rdata == fca_pkg::ENTRY_FREE);
  assign stat.clr_last   = (clr_r == AW'(TABLE_ENTRIES - 1));

  always_comb begin
    if (stat.cur_eoc || stat.cur_free) begin
      free_st = fca_pkg::ST_OK;
    end else if (stat.cur_oor) begin
      free_st = fca_pkg::ST_RANGE;
    end else begin
      free_st = fca_pkg::ST_LONG;
    end
  end

  always_comb begin
    ram_we    = (cmd.wr_sel != fca_pkg::WR_NONE);
    ram_waddr = '0;
    ram_wdata = fca_pkg::ENTRY_FREE;
    unique case (cmd.wr_sel)
      fca_pkg::WR_SET: begin
        ram_waddr = cur_r[AW-1:0];
        ram_wdata = val_r;
      end
      fca_pkg::WR_EOC: begin
        ram_waddr = scan_r[AW-1:0];
        ram_wdata = fca_pkg::ENTRY_EOC;
      end
      fca_pkg::WR_ZERO: ram_waddr = cur_r[AW-1:0];
      fca_pkg::WR_CLEAR: ram_waddr = clr_r;
      default: ram_waddr = '0;
    endcase
  end

  assign ram_raddr = cmd.rd_scan ? scan_r[AW-1:0] : cur_r[AW-1:0];

  fca_ram #(
    .WIDTH (fca_pkg::VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r  <= fca_pkg::DATA_START_RST;
      alloc_limit_r <= fca_pkg::ALLOC_LIMIT_RST;
      clr_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          fca_pkg::REG_DATA_START:  data_start_r  <= cfg_wdata;
          fca_pkg::REG_ALLOC_LIMIT: alloc_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_r   <= in_block;
      val_r   <= in_value;
      scan_r  <= SCW'(data_start_r);
      count_r <= '0;
    end
    if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.free_step) begin
      cur_r   <= ram_rdata;
      count_r <= count_r + 1'b1;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        fca_pkg::RES_READ: begin
          res_value_r <= ram_rdata;
          res_cnt_r   <= '0;
          res_st_r    <= fca_pkg::ST_OK;
        end
        fca_pkg::RES_READ_RANGE: begin
          res_value_r <= fca_pkg::ENTRY_EOC;
          res_cnt_r   <= '0;
          res_st_r    <= fca_pkg::ST_RANGE;
        end
        fca_pkg::RES_SET_OK: begin
          res_value_r <= '0;
          res_cnt_r   <= '0;
          res_st_r    <= fca_pkg::ST_OK;
        end
        fca_pkg::RES_SET_RANGE: begin
          res_value_r <= '0;
          res_cnt_r   <= '0;
          res_st_r    <= fca_pkg::ST_RANGE;
        end
        fca_pkg::RES_ALLOC: begin
          res_value_r <= fca_pkg::VAL_W'(scan_r);
          res_cnt_r   <= '0;
          res_st_r    <= fca_pkg::ST_OK;
        end
        fca_pkg::RES_FULL: begin
          res_value_r <= fca_pkg::ENTRY_EOC;
          res_cnt_r   <= '0;
          res_st_r    <= fca_pkg::ST_FULL;
        end
        default: begin
          res_value_r <= cur_r;
          res_cnt_r   <= cnt_x[fca_pkg::REG_W-1:0];
          res_st_r    <= free_st;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_value_r <= res_value_r;
      out_cnt_r   <= res_cnt_r;
      out_st_r    <= res_st_r;
    end
  end

  assign out_result_value = out_value_r;
  assign out_freed_count  = out_cnt_r;
  assign out_status       = out_st_r;

endmodule

### rtl/core/fat_chain_allocator.sv
// A read passes a request state and a data state, as the table RAM has a registered read;
// a set writes the table without a read; an allocate probes entries from the window start
// and a free clears chain entries, each entry passing a request state and a data state. One
// request is in work at a time; the next is taken in the cycle after its result is loaded,
// and a stalled result word holds the next result until it is taken. Reset is synchronous
// and active low; afterwards the table is cleared entry by entry, while no request is taken.
module fat_chain_allocator #(
  parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fca_pkg::REG_W-1:0]     cfg_wdata,
  fca_in_if.sink                        in_bus,
  fca_out_if.source                     out_bus
);

  fca_pkg::fca_cmd_t  cmd;
  fca_pkg::fca_stat_t stat;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_opcode (in_bus.opcode),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fca_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_block         (in_bus.block),
    .in_value         (in_bus.value),
    .cmd              (cmd),
    .stat             (stat),
    .out_result_value (out_bus.result_value),
    .out_freed_count  (out_bus.freed_count),
    .out_status       (out_bus.status)
  );

endmodule

### rtl/core/fca_checker.sv
// Port-level checks of the FAT chain allocator and the bind that attaches them.
// Depends on fca_pkg and the top level fat_chain_allocator.
module fca_port_checks #(
  parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fca_pkg::VAL_W-1:0] result_value,
  input logic [fca_pkg::REG_W-1:0] freed_count,
  input logic [fca_pkg::ST_W-1:0]  status
);

  localparam logic [fca_pkg::REG_W-1:0] LONG_CNT = fca_pkg::REG_W'(TABLE_ENTRIES);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(freed_count) && $stable(status))
    else $error("Result word changed while stalled.");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("Request taken before the table was cleared.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second request taken while one is in work.");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == fca_pkg::ST_FULL |->
      result_value == fca_pkg::ENTRY_EOC && freed_count == '0)
    else $error("Table full result is not end of chain with no count.");

  a_long_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == fca_pkg::ST_LONG |-> freed_count == LONG_CNT)
    else $error("Chain too long reported before the whole table was freed.");

endmodule

bind fat_chain_allocator fca_port_checks #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_fca_port_checks (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .result_value (out_bus.result_value),
  .freed_count  (out_bus.freed_count),
  .status       (out_bus.status)
);

### sim/fca_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the allocator testbench: mirrors the allocation table and the window
// registers, predicts one result word per accepted request and checks the result channel.
// Depends on fca_pkg and the request and result channel interfaces.
module fca_checker #(
  parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fca_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fca_pkg::REG_W-1:0]     cfg_wdata,
  fca_in_if                             req_mon,
  fca_out_if                            rsp_mon,
  output int                            mismatch_count,
  output int                            results_due,
  output int                            results_checked
);
  import fca_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] link;
    logic [REG_W-1:0] freed;
    logic [ST_W-1:0]  status;
  } fat_word_t;

  logic [VAL_W-1:0] fat_mirror [TABLE_ENTRIES];
  logic [REG_W-1:0] start_q;
  logic [REG_W-1:0] limit_q;
  fat_word_t        expected_words [$];
  int               fails = 0;
  int               due = 0;
  int               checked = 0;

  assign mismatch_count  = fails;
  assign results_due     = due;
  assign results_checked = checked;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic predict_table_op(input logic [OPC_W-1:0] op, input logic [VAL_W-1:0] blk,
                                  input logic [VAL_W-1:0] val, output fat_word_t want);
    int unsigned      top;
    int unsigned      idx;
    int unsigned      cnt;
    logic [VAL_W-1:0] cur;
    logic [VAL_W-1:0] nxt;
    logic             stop;
    want = '0;
    case (op)
      OP_NEXT: begin
        if (blk < TABLE_ENTRIES) begin
          want.link = fat_mirror[blk];
        end else begin
          want.link   = ENTRY_EOC;
          want.status = ST_RANGE;
        end
      end
      OP_SET: begin
        if (blk < TABLE_ENTRIES) fat_mirror[blk] = val;
        else want.status = ST_RANGE;
      end
      OP_ALLOC: begin
        top         = (limit_q > TABLE_ENTRIES) ? TABLE_ENTRIES : limit_q;
        want.link   = ENTRY_EOC;
        want.status = ST_FULL;
        idx         = start_q;
        stop        = 1'b0;
        while (!stop && idx < top) begin
          if (fat_mirror[idx] == ENTRY_FREE) begin
            fat_mirror[idx] = ENTRY_EOC;
            want.link       = idx[VAL_W-1:0];
            want.status     = ST_OK;
            stop            = 1'b1;
          end
          idx++;
        end
      end
      default: begin
        cur  = blk;
        cnt  = 0;
        stop = 1'b0;
        while (!stop && cur != ENTRY_EOC && cur != ENTRY_FREE) begin
          if (cur >= TABLE_ENTRIES) begin
            want.status = ST_RANGE;
            stop        = 1'b1;
          end else if (cnt >= TABLE_ENTRIES) begin
            want.status = ST_LONG;
            stop        = 1'b1;
          end else begin
            nxt             = fat_mirror[cur];
            fat_mirror[cur] = ENTRY_FREE;
            cnt++;
            cur = nxt;
          end
        end
        want.link  = cur;
        want.freed = cnt[REG_W-1:0];
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    fat_word_t want;
    fat_word_t got;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) fat_mirror[i] = ENTRY_FREE;
      start_q = DATA_START_RST;
      limit_q = ALLOC_LIMIT_RST;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_DATA_START) start_q = cfg_wdata;
        else if (cfg_idx == REG_ALLOC_LIMIT) limit_q = cfg_wdata;
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_table_op(req_mon.opcode, req_mon.block, req_mon.value, want);
        expected_words.push_back(want);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.link   = rsp_mon.result_value;
        got.freed  = rsp_mon.freed_count;
        got.status = rsp_mon.status;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word 0x%0h/%0d/%0d with nothing expected",
                                    got.link, got.freed, got.status));
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (got.link !== want.link)
            report_mismatch($sformatf("result_value 0x%0h, expected 0x%0h",
                                      got.link, want.link));
          if (got.freed !== want.freed)
            report_mismatch($sformatf("freed_count %0d, expected %0d", got.freed, want.freed));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
    end
    due <= expected_words.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, window register writes, request
// stimulus with random idling, and the verdict. Depends on fca_pkg, the channel
// interfaces, fat_chain_allocator and fca_checker.
module tb;
  import fca_pkg::*;

  localparam int N_ENTRIES   = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 115;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0]     cfg_wdata;
  logic                 calm;
  int                   fails;
  int                   due;
  int                   compared;
  int                   items_sent = 0;
  int                   sent_by_op [4] = '{0, 0, 0, 0};
  int                   settings = 0;
  int unsigned          window_start = DATA_START_RST;

  fca_in_if  req_bus ();
  fca_out_if rsp_bus ();

  fat_chain_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_bus   (req_bus),
    .out_bus  (rsp_bus)
  );

  fca_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .req_mon        (req_bus),
    .rsp_mon        (rsp_bus),
    .mismatch_count (fails),
    .results_due    (due),
    .results_checked(compared)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d result words outstanding.", CYCLE_LIMIT, due);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  task automatic push_request(input logic [OPC_W-1:0] op, input logic [VAL_W-1:0] blk,
                              input logic [VAL_W-1:0] val);
    while (!calm && $urandom_range(0, 99) < 33) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.opcode <= op;
    req_bus.block  <= blk;
    req_bus.value  <= val;
    do @(posedge clk); while (!req_bus.ready);
    items_sent++;
    sent_by_op[op]++;
  endtask

  task automatic program_window(input logic [REG_W-1:0] start, input logic [REG_W-1:0] limit);
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (due != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DATA_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_idx   <= REG_ALLOC_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we       <= 1'b0;
    window_start = 32'(start);
    settings++;
  endtask

  // Mostly indices just above the allocation start, so chains and frees meet allocated blocks.
  function automatic logic [VAL_W-1:0] pick_index();
    int unsigned idx;
    idx = window_start + $urandom_range(0, 63);
    if (window_start >= N_ENTRIES || idx >= N_ENTRIES || idx == 0 || $urandom_range(0, 3) == 0)
      idx = $urandom_range(1, N_ENTRIES - 1);
    return idx[VAL_W-1:0];
  endfunction

  task automatic chain_sequence();
    logic [VAL_W-1:0] links [$];
    logic [VAL_W-1:0] tail;
    int               len;
    int               k;
    len = $urandom_range(1, 12);
    for (k = 0; k < len; k++) links.push_back(pick_index());
    if ($urandom_range(0, 6) == 0) tail = VAL_W'($urandom_range(N_ENTRIES, 16'hFFFE));
    else tail = ENTRY_EOC;
    for (k = 0; k < len; k++)
      push_request(OP_SET, links[k], (k == len - 1) ? tail : links[k + 1]);
    if ($urandom_range(0, 2) == 0)
      push_request(OP_NEXT, links[$urandom_range(0, len - 1)], VAL_W'($urandom()));
    k = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len - 1)) : 0;
    push_request(OP_FREE, links[k], VAL_W'($urandom()));
  endtask

  task automatic random_sequence();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      chain_sequence();
    end else if (sel < 60) begin
      repeat ($urandom_range(1, 6))
        push_request(OP_ALLOC, VAL_W'($urandom()), VAL_W'($urandom()));
    end else if (sel < 75) begin
      push_request(OP_NEXT, ($urandom_range(0, 4) == 0) ? VAL_W'($urandom()) : pick_index(),
                   VAL_W'($urandom()));
    end else if (sel < 85) begin
      push_request(OP_SET, ($urandom_range(0, 4) == 0) ? VAL_W'($urandom()) : pick_index(),
                   ($urandom_range(0, 9) < 3) ? ENTRY_FREE : VAL_W'($urandom()));
    end else begin
      push_request(OP_FREE, ($urandom_range(0, 1) == 0) ? VAL_W'($urandom()) : pick_index(),
                   VAL_W'($urandom()));
    end
  endtask

  initial begin : stimulus
    int               ph;
    int               phase_end;
    logic [REG_W-1:0] s;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_DATA_START;
    cfg_wdata      <= '0;
    req_bus.valid  <= 1'b0;
    req_bus.opcode <= OP_NEXT;
    req_bus.block  <= '0;
    req_bus.value  <= '0;
    calm           <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window: reads and writes at the table edges, a two-block chain,
    // a walk that leaves the table, and frees that stop at once.
    push_request(OP_NEXT, 16'd0, 16'hFFFF);
    push_request(OP_NEXT, 16'd4095, 16'd0);
    push_request(OP_NEXT, 16'd4096, 16'd0);
    push_request(OP_NEXT, 16'hFFFF, 16'd0);
    push_request(OP_SET, 16'hFFFF, 16'hFFFF);
    push_request(OP_SET, 16'd4095, ENTRY_EOC);
    push_request(OP_ALLOC, 16'd0, 16'd0);
    push_request(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    push_request(OP_SET, 16'd82, 16'd83);
    push_request(OP_FREE, 16'd82, 16'd0);
    push_request(OP_NEXT, 16'd83, 16'd0);
    push_request(OP_SET, 16'd9, 16'd10);
    push_request(OP_SET, 16'd10, 16'hF000);
    push_request(OP_FREE, 16'd9, 16'd0);
    push_request(OP_FREE, ENTRY_FREE, 16'd0);
    push_request(OP_FREE, ENTRY_EOC, 16'd0);
    push_request(OP_FREE, 16'd20, 16'd0);
    push_request(OP_FREE, 16'd4096, 16'd0);

    // Window at the top of the table, then empty windows, then the whole table.
    program_window(13'd4094, 13'd4096);
    push_request(OP_ALLOC, 16'd0, 16'd0);
    push_request(OP_ALLOC, 16'd0, 16'd0);
    program_window(13'd0, 13'd0);
    push_request(OP_ALLOC, 16'd0, 16'd0);
    program_window(13'd4096, 13'd4096);
    push_request(OP_ALLOC, 16'd0, 16'd0);
    program_window(13'd0, 13'd4096);
    push_request(OP_ALLOC, 16'd0, 16'd0);
    push_request(OP_SET, 16'd0, ENTRY_FREE);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_window(DATA_START_RST, ALLOC_LIMIT_RST);
        1: program_window(13'd0, 13'd64);
        2: program_window(13'd4000, 13'd4096);
        4: program_window(13'd1, 13'd4096);
        5: program_window(13'd4096, 13'd4096);
        6: program_window(13'd2000, 13'd1000);
        default: begin
          s = REG_W'($urandom_range(1, 4000));
          program_window(s, REG_W'(s + $urandom_range(1, 48)));
        end
      endcase
      calm      <= (ph == 3);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_sequence();
    end

    req_bus.valid <= 1'b0;
    do @(posedge clk); while (due != 0);
    repeat (40) @(posedge clk);
    $display("Covered %0d requests (%0d next, %0d set, %0d alloc, %0d free) over %0d windows;",
             items_sent, sent_by_op[OP_NEXT], sent_by_op[OP_SET], sent_by_op[OP_ALLOC],
             sent_by_op[OP_FREE], settings);
    $display("%0d result words were compared and %0d mismatches found.", compared, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
